>>> design/sds_pkg.sv
// Shared types and constants of the drive supervisor.
// Used by sds_lane, sds_merge and drive_supervisor_state_machine_unit; no dependencies.
`default_nettype none

package sds_pkg;

    // Supervisor state codes.
    localparam logic [2:0] ST_INITIAL     = 3'd0;
    localparam logic [2:0] ST_READY       = 3'd1;
    localparam logic [2:0] ST_SWITCHED_ON = 3'd2;
    localparam logic [2:0] ST_OPERATION   = 3'd3;
    localparam logic [2:0] ST_FAULT       = 3'd4;

    // Axis state codes.
    localparam logic [2:0] AX_STANDBY = 3'd1;
    localparam logic [2:0] AX_ENABLED = 3'd2;
    localparam logic [2:0] AX_FAULT   = 3'd3;

    // LED blink periods in milliseconds.
    localparam logic [15:0] BLINK_INITIAL     = 16'd50;
    localparam logic [15:0] BLINK_READY       = 16'd300;
    localparam logic [15:0] BLINK_SWITCHED_ON = 16'd500;
    localparam logic [15:0] BLINK_OPERATION   = 16'd100;
    localparam logic [15:0] BLINK_SATURATE    = 16'hFFFF;

    // LED drive modes.
    localparam logic [1:0] LED_MODE_OFF    = 2'd0;
    localparam logic [1:0] LED_MODE_STEADY = 2'd1;
    localparam logic [1:0] LED_MODE_TIMED  = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_RELAY_THRESHOLD = 1'b0;
    localparam logic CFG_EVAL_PERIOD     = 1'b1;

    localparam logic [9:0] EVAL_PERIOD_RESET = 10'd10;

    typedef struct packed {
        logic standby;
        logic enabled;
        logic fault;
    } t_lane_flags;

    typedef struct packed {
        logic [2:0]  next_state;
        logic [1:0]  led_mode;
        logic [15:0] blink_period;
    } t_eval;

    typedef struct packed {
        logic [2:0] system_state;
        logic       led_level;
        logic       axes_run_enable;
        logic       soft_reset_request;
    } t_result;

endpackage

`default_nettype wire

>>> design/sds_lane.sv
// One axis lane of the drive supervisor: decodes an axis state code into flags.
// Depends on sds_pkg.
`default_nettype none

module sds_lane
    import sds_pkg::*;
(
    input  wire logic [2:0]  i_axis_state,
    output t_lane_flags      o_flags
);

    assign o_flags.standby = (i_axis_state == AX_STANDBY);
    assign o_flags.enabled = (i_axis_state == AX_ENABLED);
    assign o_flags.fault   = (i_axis_state == AX_FAULT);

endmodule

`default_nettype wire

>>> design/sds_merge.sv
// Merging stage of the drive supervisor: combines the axis lane flags with the
// current state into the next state and the LED blink rule. Depends on sds_pkg.
`default_nettype none

module sds_merge
    import sds_pkg::*;
#(
    parameter int AXIS_COUNT = 4
)
(
    input  wire logic [2:0] i_state,
    input  wire logic       i_power_ok,
    input  t_lane_flags     i_flags [AXIS_COUNT],
    output t_eval           o_eval
);

    logic w_any_standby;
    logic w_any_enabled;
    logic w_any_fault;
    logic [2:0] w_oper_next;

    always_comb begin
        w_any_standby = 1'b0;
        w_any_enabled = 1'b0;
        w_any_fault   = 1'b0;
        w_oper_next   = ST_OPERATION;
        for (int i = 0; i < AXIS_COUNT; i++) begin
            w_any_standby = w_any_standby | i_flags[i].standby;
            w_any_enabled = w_any_enabled | i_flags[i].enabled;
            w_any_fault   = w_any_fault | i_flags[i].fault;
            // The highest axis that is not enabled has the last word.
            if (!i_flags[i].enabled) begin
                w_oper_next = i_flags[i].fault ? ST_FAULT : ST_READY;
            end
        end
    end

    always_comb begin
        o_eval.next_state   = i_state;
        o_eval.led_mode     = LED_MODE_TIMED;
        o_eval.blink_period = BLINK_INITIAL;
        case (i_state)
            ST_INITIAL: begin
                if (i_power_ok) begin
                    o_eval.next_state = ST_READY;
                end
            end
            ST_READY: begin
                o_eval.blink_period = BLINK_READY;
                if (w_any_standby) begin
                    o_eval.next_state = ST_SWITCHED_ON;
                end
            end
            ST_SWITCHED_ON: begin
                o_eval.blink_period = BLINK_SWITCHED_ON;
                if (w_any_enabled) begin
                    o_eval.next_state = ST_OPERATION;
                end
            end
            ST_OPERATION: begin
                o_eval.blink_period = BLINK_OPERATION;
                o_eval.next_state   = w_oper_next;
            end
            ST_FAULT: begin
                o_eval.led_mode = LED_MODE_STEADY;
                if (!w_any_fault) begin
                    o_eval.next_state = ST_SWITCHED_ON;
                end
            end
            default: begin
                o_eval.led_mode   = LED_MODE_OFF;
                o_eval.next_state = ST_INITIAL;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> design/drive_supervisor_state_machine_unit.sv
// Drive supervisor top level: one request per millisecond tick, one result per request.
// A result reaches the head of the queue in the cycle after its request is accepted if no
// other result waits ahead; any result ahead of it must first be taken by the receiver.
// Throughput: one request per cycle; input stalls only while two results wait untaken.
// Reset (synchronous, active low): state initial, counters zero, LED off, queue empty,
// relay threshold 0 and evaluation period 10. Depends on sds_pkg, sds_lane and sds_merge.
`default_nettype none

module drive_supervisor_state_machine_unit
    import sds_pkg::*;
#(
    parameter int AXIS_COUNT = 4
)
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration write port.
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    // Request channel.
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [15:0] i_bus_voltage,
    input  wire logic [2:0]  i_axis0_state,
    input  wire logic [2:0]  i_axis1_state,
    input  wire logic [2:0]  i_axis2_state,
    input  wire logic [2:0]  i_axis3_state,
    input  wire logic        i_soft_reset_cmd,
    // Result channel.
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [2:0]       o_system_state,
    output logic             o_led_level,
    output logic             o_axes_run_enable,
    output logic             o_soft_reset_request
);

    // Configuration registers.
    logic [15:0] r_relay_threshold;
    logic [9:0]  r_eval_period;

    // Supervisor state.
    logic [2:0]  r_state, n_state;
    logic [9:0]  r_tick, n_tick;
    logic [15:0] r_blink, n_blink;
    logic        r_led, n_led;

    // Two-entry result queue; entry 0 is the head.
    t_result     r_q0, r_q1;
    logic [1:0]  r_cnt;

    logic        w_accept;
    logic        w_pop;
    logic [10:0] w_tick_inc;
    logic        w_eval;
    logic [15:0] w_blink_inc;
    t_result     w_result;
    t_eval       w_eval_info;

    logic [2:0]  w_axis [4];
    t_lane_flags w_flags [AXIS_COUNT];

    assign w_axis[0] = i_axis0_state;
    assign w_axis[1] = i_axis1_state;
    assign w_axis[2] = i_axis2_state;
    assign w_axis[3] = i_axis3_state;

    // One lane per axis in use; axes beyond AXIS_COUNT are not looked at.
    for (genvar g = 0; g < AXIS_COUNT; g++) begin : g_lane
        sds_lane u_lane (
            .i_axis_state (w_axis[g]),
            .o_flags      (w_flags[g])
        );
    end

    sds_merge #(
        .AXIS_COUNT (AXIS_COUNT)
    ) u_merge (
        .i_state    (r_state),
        .i_power_ok (i_bus_voltage > r_relay_threshold),
        .i_flags    (w_flags),
        .o_eval     (w_eval_info)
    );

    assign o_in_ready = (r_cnt != 2'd2);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_pop      = o_out_valid && i_out_ready;

    // The tick count is incremented one bit wider and compared with >=, so that a period lowered
    // below the current count, or a period of zero, still triggers an evaluation at once.
    assign w_tick_inc  = {1'b0, r_tick} + 11'd1;
    assign w_eval      = (w_tick_inc >= {1'b0, r_eval_period});
    assign w_blink_inc = (r_blink == BLINK_SATURATE) ? r_blink : r_blink + 16'd1;

    always_comb begin
        n_tick  = w_eval ? 10'd0 : w_tick_inc[9:0];
        n_blink = w_blink_inc;
        n_state = r_state;
        n_led   = r_led;
        if (w_eval) begin
            n_state = w_eval_info.next_state;
            case (w_eval_info.led_mode)
                LED_MODE_OFF: begin
                    n_led = 1'b0;
                end
                LED_MODE_STEADY: begin
                    n_led = 1'b1;
                end
                LED_MODE_TIMED: begin
                    // The period comes from the state held before this evaluation.
                    if (w_blink_inc >= w_eval_info.blink_period) begin
                        n_blink = 16'd0;
                        n_led   = ~r_led;
                    end
                end
                default: begin
                    n_led = 1'b0;
                end
            endcase
        end
    end

    assign w_result.system_state       = n_state;
    assign w_result.led_level          = n_led;
    assign w_result.axes_run_enable    = (n_state >= ST_SWITCHED_ON) && (n_state <= ST_FAULT);
    assign w_result.soft_reset_request = w_eval && i_soft_reset_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_relay_threshold <= 16'd0;
            r_eval_period     <= EVAL_PERIOD_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_RELAY_THRESHOLD: r_relay_threshold <= i_cfg_data;
                CFG_EVAL_PERIOD:     r_eval_period     <= i_cfg_data[9:0];
                default:             r_relay_threshold <= r_relay_threshold;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INITIAL;
            r_tick  <= 10'd0;
            r_blink <= 16'd0;
            r_led   <= 1'b0;
        end else if (w_accept) begin
            r_state <= n_state;
            r_tick  <= n_tick;
            r_blink <= n_blink;
            r_led   <= n_led;
        end
    end

    // Queue control: a request may enter while the head result is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            case ({w_accept, w_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            if (w_accept && (r_cnt == 2'd1)) begin
                r_q0 <= w_result;
            end else begin
                r_q0 <= r_q1;
            end
            if (w_accept && (r_cnt == 2'd2)) begin
                r_q1 <= w_result;
            end
        end else if (w_accept) begin
            if (r_cnt == 2'd0) begin
                r_q0 <= w_result;
            end else begin
                r_q1 <= w_result;
            end
        end
    end

    assign o_out_valid          = (r_cnt != 2'd0);
    assign o_system_state       = r_q0.system_state;
    assign o_led_level          = r_q0.led_level;
    assign o_axes_run_enable    = r_q0.axes_run_enable;
    assign o_soft_reset_request = r_q0.soft_reset_request;

    // The queue never holds more than two results.
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt != 2'd3)
        else $error("result queue count out of range");

    // An accepted request always leaves a result to be taken in the next cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n) w_accept |=> o_out_valid)
        else $error("accepted request produced no result");

    // The supervisor never reaches an unused state code.
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_state <= ST_FAULT)
        else $error("supervisor in unused state");

    // An evaluation always restarts the tick counter.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_eval) |=> (r_tick == 10'd0))
        else $error("tick counter not cleared at evaluation");

    // A result carries the run enable that matches its state.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_axes_run_enable ==
            ((o_system_state >= ST_SWITCHED_ON) && (o_system_state <= ST_FAULT))))
        else $error("run enable does not match state");

endmodule

`default_nettype wire

>>> tb/sv/drive_supervisor_state_machine_unit_tb.sv
// Self-checking testbench for drive_supervisor_state_machine_unit: directed walks, random traffic
// and a fault soak, checked against a cycle-free predictor of the supervisor.
// Depends on sds_pkg and the RTL of drive_supervisor_state_machine_unit only.
`timescale 1ns / 100ps

module drive_supervisor_state_machine_unit_tb
    import sds_pkg::*;
();

    localparam int CLK_PERIOD      = 4;
    localparam int NUM_AXES        = 4;
    localparam int HOLD_OFF_CYCLES = 200;
    // Long enough in fault diagnose for the blink counter to pass the switched-on period.
    localparam int SOAK_TICKS      = 520;
    localparam int LIMIT_NS        = 5_000_000;
    localparam logic [15:0] BLINK_NONE = 16'd0;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [15:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [15:0] i_bus_voltage;
    logic [2:0]  i_axis0_state;
    logic [2:0]  i_axis1_state;
    logic [2:0]  i_axis2_state;
    logic [2:0]  i_axis3_state;
    logic        i_soft_reset_cmd;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [2:0]  o_system_state;
    logic        o_led_level;
    logic        o_axes_run_enable;
    logic        o_soft_reset_request;

    drive_supervisor_state_machine_unit #(
        .AXIS_COUNT(NUM_AXES)
    ) dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_bus_voltage       (i_bus_voltage),
        .i_axis0_state       (i_axis0_state),
        .i_axis1_state       (i_axis1_state),
        .i_axis2_state       (i_axis2_state),
        .i_axis3_state       (i_axis3_state),
        .i_soft_reset_cmd    (i_soft_reset_cmd),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_system_state      (o_system_state),
        .o_led_level         (o_led_level),
        .o_axes_run_enable   (o_axes_run_enable),
        .o_soft_reset_request(o_soft_reset_request)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Predictor state: a private copy of the supervisor registers and configuration.
    logic [15:0] relay_level;
    logic [9:0]  eval_ticks;
    logic [2:0]  sup_state;
    logic [9:0]  tick_count;
    logic [15:0] blink_ms;
    logic        led_on;

    // Predicted status words, oldest first, one per accepted request.
    t_result predicted_status[$];
    int      failures = 0;

    // Idling controls shared by the sender task and the receiver process.
    bit send_idle_on = 1'b0;
    bit recv_idle_on = 1'b0;
    bit hold_off_req = 1'b0;

    // Advances the predictor by one millisecond tick and returns the status after it.
    function automatic t_result supervise_tick(input logic [15:0] volts, input logic [11:0] axes,
                                               input logic cmd);
        t_result     status;
        logic [10:0] cnt;
        logic [2:0]  nxt;
        logic [15:0] period;
        logic [2:0]  code;
        logic        any_fault;
        logic        req;
        int          i;
        req = 1'b0;
        if (blink_ms != 16'hFFFF) begin
            blink_ms = blink_ms + 16'd1;
        end
        // An 11-bit count compared with >=, so that a period of zero still evaluates every tick.
        cnt = {1'b0, tick_count} + 11'd1;
        if (cnt >= {1'b0, eval_ticks}) begin
            cnt = '0;
            req = cmd;
            nxt = sup_state;
            any_fault = 1'b0;
            case (sup_state)
                ST_INITIAL: begin
                    period = BLINK_INITIAL;
                    if (volts > relay_level) nxt = ST_READY;
                end
                ST_READY: begin
                    period = BLINK_READY;
                    for (i = 0; i < NUM_AXES; i++) begin
                        if (axes[3*i +: 3] == AX_STANDBY) nxt = ST_SWITCHED_ON;
                    end
                end
                ST_SWITCHED_ON: begin
                    period = BLINK_SWITCHED_ON;
                    for (i = 0; i < NUM_AXES; i++) begin
                        if (axes[3*i +: 3] == AX_ENABLED) nxt = ST_OPERATION;
                    end
                end
                ST_OPERATION: begin
                    // The highest axis that is not enabled has the last word.
                    period = BLINK_OPERATION;
                    for (i = 0; i < NUM_AXES; i++) begin
                        code = axes[3*i +: 3];
                        if (code == AX_FAULT) nxt = ST_FAULT;
                        else if (code != AX_ENABLED) nxt = ST_READY;
                    end
                end
                ST_FAULT: begin
                    period = BLINK_SATURATE;
                    for (i = 0; i < NUM_AXES; i++) begin
                        if (axes[3*i +: 3] == AX_FAULT) any_fault = 1'b1;
                    end
                    if (!any_fault) nxt = ST_SWITCHED_ON;
                end
                default: begin
                    period = BLINK_NONE;
                    nxt = ST_INITIAL;
                end
            endcase
            sup_state = nxt;
            // The blink period belongs to the state before this evaluation.
            if (period == BLINK_NONE) begin
                led_on = 1'b0;
            end else if (period == BLINK_SATURATE) begin
                led_on = 1'b1;
            end else if (blink_ms >= period) begin
                blink_ms = '0;
                led_on = ~led_on;
            end
        end
        tick_count = cnt[9:0];
        status.system_state       = sup_state;
        status.led_level          = led_on;
        status.axes_run_enable    = (sup_state >= ST_SWITCHED_ON) && (sup_state <= ST_FAULT);
        status.soft_reset_request = req;
        return status;
    endfunction

    // Everything is sampled at the rising edge, before the block's registers move.
    // Configuration writes, accepted requests and accepted results all pass through here.
    always @(posedge i_clk) begin : monitor
        t_result want;
        if (!i_rst_n) begin
            relay_level = '0;
            eval_ticks  = EVAL_PERIOD_RESET;
            sup_state   = ST_INITIAL;
            tick_count  = '0;
            blink_ms    = '0;
            led_on      = 1'b0;
            predicted_status.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_RELAY_THRESHOLD) relay_level = i_cfg_data;
                else if (i_cfg_index == CFG_EVAL_PERIOD) eval_ticks = i_cfg_data[9:0];
            end
            if (i_in_valid && o_in_ready) begin
                predicted_status.push_back(supervise_tick(i_bus_voltage,
                    {i_axis3_state, i_axis2_state, i_axis1_state, i_axis0_state},
                    i_soft_reset_cmd));
            end
            if (o_out_valid && i_out_ready) begin
                if (predicted_status.size() == 0) begin
                    failures++;
                    if (failures <= 10) begin
                        $display("%0t: result with no request outstanding: state %0d led %0b",
                                 $time, o_system_state, o_led_level);
                    end
                end else begin
                    want = predicted_status.pop_front();
                    if (o_system_state != want.system_state || o_led_level != want.led_level ||
                        o_axes_run_enable != want.axes_run_enable ||
                        o_soft_reset_request != want.soft_reset_request) begin
                        failures++;
                        if (failures <= 10) begin
                            $display({"%0t: expected state %0d led %0b run %0b sreset %0b, ",
                                      "got %0d %0b %0b %0b"},
                                     $time, want.system_state, want.led_level,
                                     want.axes_run_enable, want.soft_reset_request,
                                     o_system_state, o_led_level, o_axes_run_enable,
                                     o_soft_reset_request);
                        end
                    end
                end
            end
        end
    end

    // Result side. A long hold-off asked for by a test is counted here, so that the
    // sender keeps offering requests until the block's queue is full and it stalls.
    initial begin : result_sink
        int hold;
        i_out_ready = 1'b0;
        @(negedge i_clk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold = HOLD_OFF_CYCLES;
                i_out_ready <= 1'b0;
            end else if (recv_idle_on && $urandom_range(0, 5) == 0) begin
                hold = $urandom_range(1, 16);
                i_out_ready <= 1'b0;
            end else begin
                hold = 1;
                i_out_ready <= 1'b1;
            end
            repeat (hold) @(negedge i_clk);
        end
    end

    function automatic logic [11:0] pack_axes(input logic [2:0] a3, input logic [2:0] a2,
                                              input logic [2:0] a1, input logic [2:0] a0);
        return {a3, a2, a1, a0};
    endfunction

    // Offers one tick request and returns at the falling edge after it was accepted.
    // Valid stays high on return; the next call or a register write decides what follows.
    task automatic send_tick(input logic [15:0] volts, input logic [11:0] axes, input logic cmd);
        int gap;
        gap = 0;
        if (send_idle_on && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 16);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_bus_voltage    <= volts;
        i_axis0_state    <= axes[2:0];
        i_axis1_state    <= axes[5:3];
        i_axis2_state    <= axes[8:6];
        i_axis3_state    <= axes[11:9];
        i_soft_reset_cmd <= cmd;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Registers change only with the block idle: no request offered, every result back.
    task automatic write_register(input logic index, input logic [15:0] value);
        i_in_valid <= 1'b0;
        while (predicted_status.size() != 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Axis codes drawn according to a traffic profile: mixed, running, standby or faulty.
    function automatic logic [11:0] random_axes(input int profile);
        logic [11:0] axes;
        int          i;
        int          roll;
        for (i = 0; i < NUM_AXES; i++) begin
            roll = $urandom_range(0, 99);
            axes[3*i +: 3] = 3'($urandom_range(0, 7));
            case (profile)
                1: if (roll < 90) axes[3*i +: 3] = AX_ENABLED;
                2: begin
                    if (roll < 60) axes[3*i +: 3] = AX_STANDBY;
                    else if (roll < 70) axes[3*i +: 3] = AX_ENABLED;
                end
                3: if (roll < 40) axes[3*i +: 3] = AX_FAULT;
                default: ;
            endcase
        end
        return axes;
    endfunction

    // Mostly uniform voltages, with some right at the relay threshold and one above it.
    function automatic logic [15:0] random_volts();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return relay_level;
        if (roll == 1 && relay_level != 16'hFFFF) return relay_level + 16'd1;
        return 16'($urandom_range(0, 65535));
    endfunction

    // Reset values: a period of ten, threshold zero, so the tenth tick leaves initial
    // and only that tick passes the soft-reset command through.
    task automatic test_reset_values();
        repeat (11) send_tick(16'hFFFF, pack_axes(3'd7, 3'd7, 3'd7, 3'd7), 1'b1);
    endtask

    // Every transition but the one out of initial, with an evaluation on each tick, including the
    // rule that the highest non-enabled axis decides how operation enabled is left.
    task automatic test_state_walk();
        write_register(CFG_RELAY_THRESHOLD, 16'd1000);
        write_register(CFG_EVAL_PERIOD, 16'd1);
        send_tick(16'd0,    pack_axes(3'd0, 3'd0, 3'd0, 3'd0), 1'b0);
        send_tick(16'd1000, pack_axes(3'd0, 3'd0, 3'd0, 3'd0), 1'b0);
        send_tick(16'd1001, pack_axes(3'd0, 3'd0, 3'd0, 3'd0), 1'b1);
        send_tick(16'd0,    pack_axes(3'd7, 3'd7, 3'd0, AX_ENABLED), 1'b0);
        send_tick(16'd0,    pack_axes(AX_STANDBY, 3'd7, 3'd7, 3'd7), 1'b0);
        send_tick(16'd0,    pack_axes(AX_FAULT, AX_STANDBY, 3'd0, 3'd0), 1'b1);
        send_tick(16'd0,    pack_axes(3'd0, 3'd0, 3'd0, AX_ENABLED), 1'b0);
        send_tick(16'hFFFF, pack_axes(AX_ENABLED, AX_ENABLED, AX_ENABLED, AX_ENABLED), 1'b1);
        send_tick(16'd5,    pack_axes(3'd7, AX_ENABLED, AX_FAULT, AX_ENABLED), 1'b0);
        send_tick(16'd5,    pack_axes(3'd0, 3'd0, 3'd0, AX_STANDBY), 1'b0);
        send_tick(16'd5,    pack_axes(3'd0, AX_ENABLED, 3'd0, 3'd0), 1'b0);
        send_tick(16'd5,    pack_axes(AX_FAULT, AX_ENABLED, 3'd7, AX_ENABLED), 1'b0);
        send_tick(16'd5,    pack_axes(3'd0, 3'd0, 3'd0, AX_FAULT), 1'b1);
        send_tick(16'd5,    pack_axes(AX_ENABLED, AX_ENABLED, AX_ENABLED, AX_ENABLED), 1'b0);
        send_tick(16'd5,    pack_axes(AX_ENABLED, AX_ENABLED, AX_ENABLED, AX_ENABLED), 1'b0);
        send_tick(16'd5,    pack_axes(AX_STANDBY, AX_ENABLED, AX_ENABLED, AX_ENABLED), 1'b0);
    endtask

    // A zero period acts as one; bits above the period width are dropped; the largest
    // period and threshold hold the supervisor still.
    task automatic test_period_extremes();
        write_register(CFG_EVAL_PERIOD, 16'd0);
        repeat (3) send_tick(16'hFFFF, pack_axes(3'd0, 3'd0, 3'd0, AX_STANDBY), 1'b1);
        write_register(CFG_EVAL_PERIOD, 16'hFC03);
        repeat (4) send_tick(16'h0000, pack_axes(3'd0, 3'd0, AX_ENABLED, 3'd0), 1'b1);
        write_register(CFG_RELAY_THRESHOLD, 16'hFFFF);
        write_register(CFG_EVAL_PERIOD, 16'h03FF);
        repeat (3) send_tick(16'hFFFF, pack_axes(3'd7, 3'd7, 3'd7, 3'd7), 1'b1);
    endtask

    // The receiver holds off for a long stretch while requests keep coming.
    task automatic test_result_backpressure();
        write_register(CFG_RELAY_THRESHOLD, 16'd0);
        write_register(CFG_EVAL_PERIOD, 16'd2);
        hold_off_req = 1'b1;
        repeat (30) send_tick(random_volts(), random_axes(1), 1'($urandom_range(0, 1)));
    endtask

    // Random traffic in phases with fresh register settings. Within a phase, runs of
    // requests follow one profile so that the supervisor climbs to operation and stays.
    task automatic test_random_traffic();
        int phase;
        int sent;
        int run_len;
        int profile;
        logic [9:0] period;
        for (phase = 0; phase < 10; phase++) begin
            if ($urandom_range(0, 9) == 0) period = 10'($urandom_range(10, 60));
            else period = 10'($urandom_range(0, 3));
            case ($urandom_range(0, 5))
                0: write_register(CFG_RELAY_THRESHOLD, 16'd0);
                1: write_register(CFG_RELAY_THRESHOLD, 16'hFFFF);
                default: write_register(CFG_RELAY_THRESHOLD, 16'($urandom_range(0, 65535)));
            endcase
            write_register(CFG_EVAL_PERIOD, {6'($urandom_range(0, 63)), period});
            sent = 0;
            while (sent < 55) begin
                run_len = $urandom_range(10, 40);
                profile = $urandom_range(0, 3);
                // The last phases run with no idling on either side.
                send_idle_on = (phase < 8) && ($urandom_range(0, 2) != 0);
                recv_idle_on = (phase < 8) && ($urandom_range(0, 2) != 0);
                repeat (run_len) send_tick(random_volts(), random_axes(profile),
                                           1'($urandom_range(0, 1)));
                sent += run_len;
            end
        end
    endtask

    // Parks the supervisor in fault diagnose while the blink counter keeps running, then
    // leaves: the first evaluation in switched on must toggle the LED at once.
    task automatic test_fault_soak();
        send_idle_on = 1'b0;
        recv_idle_on = 1'b0;
        write_register(CFG_RELAY_THRESHOLD, 16'd0);
        write_register(CFG_EVAL_PERIOD, 16'd1);
        repeat (SOAK_TICKS) send_tick(16'hFFFF, pack_axes(AX_FAULT, AX_ENABLED, AX_STANDBY, 3'd0),
                                      1'b0);
        repeat (3) send_tick(16'hFFFF, pack_axes(AX_STANDBY, AX_STANDBY, AX_STANDBY, AX_STANDBY),
                             1'b0);
    endtask

    initial begin
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_index      = CFG_RELAY_THRESHOLD;
        i_cfg_data       = '0;
        i_in_valid       = 1'b0;
        i_bus_voltage    = '0;
        i_axis0_state    = '0;
        i_axis1_state    = '0;
        i_axis2_state    = '0;
        i_axis3_state    = '0;
        i_soft_reset_cmd = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_values();
        send_idle_on = 1'b1;
        recv_idle_on = 1'b1;
        test_state_walk();
        test_period_extremes();
        test_result_backpressure();
        test_random_traffic();
        test_fault_soak();

        // Drain: every result back, then a wait for anything stray.
        i_in_valid <= 1'b0;
        while (predicted_status.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        if (failures == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin : watchdog
        #LIMIT_NS;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
